/* src/ump_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ump_pkg
// Shared widths, fixed-point constants and the CORDIC arctangent table for the
// unicycle motion step unit.
// ----------------------------------------------------------------------------
package ump_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TRIG_Q    = 30;
	localparam int ANG_SHIFT = TRIG_Q - FRAC_BITS;

	localparam int POS_W   = 24;
	localparam int HEAD_W  = 20;
	localparam int SPEED_W = 17;
	localparam int RATE_W  = 17;
	localparam int DT_W    = 16;

	localparam int ANG_W  = 36;
	localparam int Z_W    = 34;
	localparam int XY_W   = 34;
	localparam int NH_W   = 20;
	localparam int DVS_W  = 17;

	localparam int REDUCE_STEPS = 3;
	localparam int PREP_STAGES  = REDUCE_STEPS + 1;
	localparam int ATAN_ENTRIES = 24;

	localparam logic [DT_W-1:0] TIME_STEP_RST = 16'd6554;

	localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032875;

	function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
		logic signed [Z_W-1:0] r;
		case (idx)
			0:  r = 34'sd843314857;
			1:  r = 34'sd497837829;
			2:  r = 34'sd263043837;
			3:  r = 34'sd133525159;
			4:  r = 34'sd67021687;
			5:  r = 34'sd33543516;
			6:  r = 34'sd16775851;
			7:  r = 34'sd8388437;
			8:  r = 34'sd4194283;
			9:  r = 34'sd2097149;
			10: r = 34'sd1048576;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* src/unicycle_motion_step_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicycle_motion_step_unit
// Advances a unicycle pose by one time step: straight line at zero turn rate,
// exact circular arc otherwise (CORDIC sine/cosine and a pipelined divider).
// ----------------------------------------------------------------------------
// channel  | dir | fields (low bit up)
// s_axis   | in  | tdata: pos_x[23:0] pos_y[47:24] heading[67:48]
//          |     |        speed[84:68] turn_rate[101:85], zero pad to 104
// m_axis   | out | tdata: next_x[23:0] next_y[47:24] next_heading[67:48],
//          |     |        zero pad to 72
// cfg      | in  | cfg_wr_en / cfg_wr_data: time_step, unsigned Q0.16
//
// One request per cycle while the skid register is empty; the pipeline length is set by
// the CORDIC stages and the 20-stage quotient pipeline.
// Reset clears all valid bits and loads time_step with 6554.
// One global enable moves every stage; a skid register behind the output
// register catches the item in flight, so tready depends on the skid alone.
// ----------------------------------------------------------------------------
module unicycle_motion_step_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [103:0]  s_axis_tdata,   // pos_x, pos_y, heading, speed, turn_rate
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [71:0]   m_axis_tdata,   // next_x, next_y, next_heading
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data
);
	import ump_pkg::*;

	localparam int SEG2_N = PREP_STAGES + CORDIC_STEPS;
	localparam int VLD_N  = 3 + SEG2_N + 4 + NH_W;
	localparam int PRD_W  = 53;
	localparam int DIF_W  = XY_W + 1;
	localparam int RX_W   = 21;
	localparam logic [33:0]      RND16 = 34'd1 << (FRAC_BITS - 1);
	localparam logic [PRD_W-1:0] RND30 = 53'd1 << (TRIG_Q - 1);

	typedef struct packed {
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [HEAD_W-1:0] hd;
		logic [SPEED_W-1:0]       spd;
		logic signed [RATE_W-1:0] w;
		logic [17:0]              d;
	} side2_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [HEAD_W-1:0] hd;
		logic                     zero;
		logic                     sgnx;
		logic                     sgny;
		logic signed [RX_W-1:0]   rx;
		logic signed [RX_W-1:0]   ry;
	} side3_t;

	typedef struct packed {
		logic signed [HEAD_W-1:0] hd;
		logic signed [POS_W-1:0]  ny;
		logic signed [POS_W-1:0]  nx;
	} out_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
		logic signed [POS_W-1:0] r;
		if (v[POS_W] != v[POS_W-1])
			r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	function automatic logic signed [HEAD_W-1:0] sat_head(input logic signed [HEAD_W:0] v);
		logic signed [HEAD_W-1:0] r;
		if (v[HEAD_W] != v[HEAD_W-1])
			r = v[HEAD_W] ? {1'b1, {(HEAD_W-1){1'b0}}} : {1'b0, {(HEAD_W-1){1'b1}}};
		else
			r = v[HEAD_W-1:0];
		return r;
	endfunction

	logic             en;
	logic [DT_W-1:0]  time_step_q;
	logic             vld_s [VLD_N];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
		end else if (cfg_wr_en) begin
			time_step_q <= cfg_wr_data;
		end
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VLD_N; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < VLD_N; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// ---- s1: products with the time step
	logic signed [POS_W-1:0]  px_s1, py_s1;
	logic signed [HEAD_W-1:0] th_s1;
	logic [SPEED_W-1:0]       spd_s1;
	logic signed [RATE_W-1:0] w_s1;
	logic signed [33:0]       wdt_s1;
	logic [32:0]              vdt_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= s_axis_tdata[23:0];
			py_s1  <= s_axis_tdata[47:24];
			th_s1  <= s_axis_tdata[67:48];
			spd_s1 <= s_axis_tdata[84:68];
			w_s1   <= s_axis_tdata[101:85];
			wdt_s1 <= $signed(s_axis_tdata[101:85]) * $signed({1'b0, time_step_q});
			vdt_s1 <= s_axis_tdata[84:68] * time_step_q;
		end
	end

	// ---- s2: round to Q.16
	logic [33:0]              wdt_mag, wdt_rnd, vdt_rnd;
	logic signed [18:0]       dth_w;
	logic signed [POS_W-1:0]  px_s2, py_s2;
	logic signed [HEAD_W-1:0] th_s2;
	logic [SPEED_W-1:0]       spd_s2;
	logic signed [RATE_W-1:0] w_s2;
	logic signed [18:0]       dth_s2;
	logic [17:0]              d_s2;

	always_comb begin
		wdt_mag = wdt_s1[33] ? 34'(-wdt_s1) : 34'(wdt_s1);
		wdt_rnd = wdt_mag + RND16;
		dth_w   = wdt_s1[33] ? -$signed({1'b0, wdt_rnd[33:16]})
		                     : $signed({1'b0, wdt_rnd[33:16]});
		vdt_rnd = {1'b0, vdt_s1} + RND16;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			th_s2  <= th_s1;
			spd_s2 <= spd_s1;
			w_s2   <= w_s1;
			dth_s2 <= dth_w;
			d_s2   <= vdt_rnd[33:16];
		end
	end

	// ---- s3: new heading and Q.30 angles
	logic signed [HEAD_W:0]   hsum;
	logic signed [ANG_W-1:0]  a0_s3, a1_s3;
	side2_t                   sd_s3;

	assign hsum = $signed({th_s2[HEAD_W-1], th_s2}) +
	              $signed({{(HEAD_W+1-19){dth_s2[18]}}, dth_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			a0_s3 <= $signed({{(ANG_W-HEAD_W-ANG_SHIFT){th_s2[HEAD_W-1]}}, th_s2,
			                  {ANG_SHIFT{1'b0}}});
			a1_s3 <= $signed({{(ANG_W-HEAD_W-1-ANG_SHIFT){hsum[HEAD_W]}}, hsum,
			                  {ANG_SHIFT{1'b0}}});
			sd_s3.px  <= px_s2;
			sd_s3.py  <= py_s2;
			sd_s3.hd  <= sat_head(hsum);
			sd_s3.spd <= spd_s2;
			sd_s3.w   <= w_s2;
			sd_s3.d   <= d_s2;
		end
	end

	// ---- angle reduction and CORDIC, two angles side by side
	logic signed [Z_W-1:0]  z0, z1;
	logic                   fn0, fn1, cn0, cn1;
	logic signed [XY_W-1:0] cx0, cy0, cx1, cy1;

	ump_angle_prep u_prep0 (.clk, .en, .a_in(a0_s3), .z_out(z0), .neg_out(fn0));
	ump_angle_prep u_prep1 (.clk, .en, .a_in(a1_s3), .z_out(z1), .neg_out(fn1));

	ump_cordic #(.STEPS(CORDIC_STEPS)) u_cordic0 (
		.clk, .en, .z_in(z0), .neg_in(fn0), .x_out(cx0), .y_out(cy0), .neg_out(cn0));
	ump_cordic #(.STEPS(CORDIC_STEPS)) u_cordic1 (
		.clk, .en, .z_in(z1), .neg_in(fn1), .x_out(cx1), .y_out(cy1), .neg_out(cn1));

	side2_t side2_s [SEG2_N];

	always_ff @(posedge clk) begin
		if (en) begin
			side2_s[0] <= sd_s3;
			for (int i = 1; i < SEG2_N; i++) side2_s[i] <= side2_s[i-1];
		end
	end

	// ---- s4: undo the fold
	logic signed [XY_W-1:0] s0_s4, c0_s4, s1_s4, c1_s4;
	side2_t                 sd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			s0_s4 <= cn0 ? -cy0 : cy0;
			c0_s4 <= cn0 ? -cx0 : cx0;
			s1_s4 <= cn1 ? -cy1 : cy1;
			c1_s4 <= cn1 ? -cx1 : cx1;
			sd_s4 <= side2_s[SEG2_N-1];
		end
	end

	// ---- s5: sine and cosine differences
	logic signed [DIF_W-1:0] ds_s5, dc_s5;
	logic signed [XY_W-1:0]  s0_s5, c0_s5;
	side2_t                  sd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s5 <= $signed({s1_s4[XY_W-1], s1_s4}) - $signed({s0_s4[XY_W-1], s0_s4});
			dc_s5 <= $signed({c0_s4[XY_W-1], c0_s4}) - $signed({c1_s4[XY_W-1], c1_s4});
			s0_s5 <= s0_s4;
			c0_s5 <= c0_s4;
			sd_s5 <= sd_s4;
		end
	end

	// ---- s6: speed times difference, distance times trig
	logic signed [PRD_W-1:0] nx_s6, ny_s6, sx_s6, sy_s6;
	side2_t                  sd_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s6 <= $signed({1'b0, sd_s5.spd}) * ds_s5;
			ny_s6 <= $signed({1'b0, sd_s5.spd}) * dc_s5;
			sx_s6 <= $signed({1'b0, sd_s5.d}) * c0_s5;
			sy_s6 <= $signed({1'b0, sd_s5.d}) * s0_s5;
			sd_s6 <= sd_s5;
		end
	end

	// ---- s7: dividend with half-divisor bias, straight-path rounding
	logic [PRD_W-1:0]  nxm, nym, sxm, sym, wsh, nxb, nyb, sxr, syr;
	logic [DVS_W-1:0]  wm;
	logic [NH_W-1:0]   nhx_s7, nhy_s7;
	logic [DVS_W-1:0]  dvs_s7;
	side3_t            sd_s7;

	always_comb begin
		wm  = sd_s6.w[RATE_W-1] ? DVS_W'(-sd_s6.w) : DVS_W'(sd_s6.w);
		wsh = PRD_W'(wm) << (TRIG_Q - 1);
		nxm = nx_s6[PRD_W-1] ? PRD_W'(-nx_s6) : PRD_W'(nx_s6);
		nym = ny_s6[PRD_W-1] ? PRD_W'(-ny_s6) : PRD_W'(ny_s6);
		sxm = sx_s6[PRD_W-1] ? PRD_W'(-sx_s6) : PRD_W'(sx_s6);
		sym = sy_s6[PRD_W-1] ? PRD_W'(-sy_s6) : PRD_W'(sy_s6);
		nxb = nxm + wsh;
		nyb = nym + wsh;
		sxr = sxm + RND30;
		syr = sym + RND30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nhx_s7     <= nxb[TRIG_Q +: NH_W];
			nhy_s7     <= nyb[TRIG_Q +: NH_W];
			dvs_s7     <= wm;
			sd_s7.px   <= sd_s6.px;
			sd_s7.py   <= sd_s6.py;
			sd_s7.hd   <= sd_s6.hd;
			sd_s7.zero <= (sd_s6.w == '0);
			sd_s7.sgnx <= nx_s6[PRD_W-1] ^ sd_s6.w[RATE_W-1];
			sd_s7.sgny <= ny_s6[PRD_W-1] ^ sd_s6.w[RATE_W-1];
			sd_s7.rx   <= sx_s6[PRD_W-1] ? -$signed({1'b0, sxr[TRIG_Q +: RX_W-1]})
			                             : $signed({1'b0, sxr[TRIG_Q +: RX_W-1]});
			sd_s7.ry   <= sy_s6[PRD_W-1] ? -$signed({1'b0, syr[TRIG_Q +: RX_W-1]})
			                             : $signed({1'b0, syr[TRIG_Q +: RX_W-1]});
		end
	end

	// ---- quotient pipelines
	logic [NH_W-1:0] qx, qy;

	ump_div u_divx (.clk, .en, .num_in(nhx_s7), .dvs_in(dvs_s7), .q_out(qx));
	ump_div u_divy (.clk, .en, .num_in(nhy_s7), .dvs_in(dvs_s7), .q_out(qy));

	side3_t side3_s [NH_W];

	always_ff @(posedge clk) begin
		if (en) begin
			side3_s[0] <= sd_s7;
			for (int i = 1; i < NH_W; i++) side3_s[i] <= side3_s[i-1];
		end
	end

	// ---- final sums
	side3_t                 tl;
	logic signed [RX_W-1:0] dx, dy;
	logic signed [POS_W:0]  sumx, sumy;
	out_t                   res;

	always_comb begin
		tl = side3_s[NH_W-1];
		if (tl.zero) begin
			dx = tl.rx;
			dy = tl.ry;
		end else begin
			dx = tl.sgnx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
			dy = tl.sgny ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		end
		sumx   = $signed({tl.px[POS_W-1], tl.px}) +
		         $signed({{(POS_W+1-RX_W){dx[RX_W-1]}}, dx});
		sumy   = $signed({tl.py[POS_W-1], tl.py}) +
		         $signed({{(POS_W+1-RX_W){dy[RX_W-1]}}, dy});
		res.nx = sat_pos(sumx);
		res.ny = sat_pos(sumy);
		res.hd = tl.hd;
	end

	// ---- output register and skid
	logic tail_v, take;
	logic out_v_q, sk_v_q;
	out_t out_q, sk_q;

	assign en     = !sk_v_q;
	assign tail_v = vld_s[VLD_N-1] && en;
	assign take   = out_v_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			// drain skid once the output frees up
			if (take) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= tail_v;
		end else if (tail_v) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (take) out_q <= sk_q;
		end else if (!out_v_q || take) begin
			out_q <= res;
		end else begin
			sk_q <= res;
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'b0, out_q};

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid holds a request while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && !m_axis_tready && vld_s[VLD_N-1]))
		else $error("skid filled without a stalled output and a finished request");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sk_v_q) |-> $past(m_axis_tready) && out_v_q)
		else $error("skid drained without a taken output");
`endif

endmodule

/* src/ump_angle_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ump_angle_prep
// Reduces a Q.30 angle to (-pi, pi] by whole turns, one turn per stage, then
// folds it into [-pi/2, pi/2] and flags the sign flip of sin and cos.
// ----------------------------------------------------------------------------
module ump_angle_prep (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ump_pkg::ANG_W-1:0]    a_in,
	output logic signed [ump_pkg::Z_W-1:0]      z_out,
	output logic                                neg_out
);
	import ump_pkg::*;

	logic signed [ANG_W-1:0] red_s [REDUCE_STEPS];
	logic signed [ANG_W-1:0] fold_w;
	logic signed [Z_W-1:0]   z_s;
	logic                    neg_s;

	for (genvar i = 0; i < REDUCE_STEPS; i++) begin : g_red
		logic signed [ANG_W-1:0] ap;
		if (i == 0) begin : g_first
			assign ap = a_in;
		end else begin : g_next
			assign ap = red_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (ap > PI_Q30)
					red_s[i] <= ap - TWO_PI_Q30;
				else if (ap <= -PI_Q30)
					red_s[i] <= ap + TWO_PI_Q30;
				else
					red_s[i] <= ap;
			end
		end
	end

	always_comb begin
		if (red_s[REDUCE_STEPS-1] > HALF_PI_Q30)
			fold_w = red_s[REDUCE_STEPS-1] - PI_Q30;
		else if (red_s[REDUCE_STEPS-1] < -HALF_PI_Q30)
			fold_w = red_s[REDUCE_STEPS-1] + PI_Q30;
		else
			fold_w = red_s[REDUCE_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s   <= fold_w[Z_W-1:0];
			neg_s <= (red_s[REDUCE_STEPS-1] > HALF_PI_Q30) ||
			         (red_s[REDUCE_STEPS-1] < -HALF_PI_Q30);
		end
	end

	assign z_out   = z_s;
	assign neg_out = neg_s;

endmodule

/* src/ump_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ump_cordic
// Rotation-mode CORDIC in Q4.30, one micro-rotation per stage, gain applied
// up front. Carries the fold flag alongside.
// ----------------------------------------------------------------------------
module ump_cordic #(
	parameter int STEPS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ump_pkg::Z_W-1:0]    z_in,
	input  logic                              neg_in,
	output logic signed [ump_pkg::XY_W-1:0]   x_out,
	output logic signed [ump_pkg::XY_W-1:0]   y_out,
	output logic                              neg_out
);
	import ump_pkg::*;

	logic signed [XY_W-1:0] x_s   [STEPS];
	logic signed [XY_W-1:0] y_s   [STEPS];
	logic signed [Z_W-1:0]  z_s   [STEPS];
	logic                   neg_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [XY_W-1:0] xp, yp, xsh, ysh;
		logic signed [Z_W-1:0]  zp;
		logic                   np;
		if (i == 0) begin : g_first
			assign xp = GAIN_Q30;
			assign yp = '0;
			assign zp = z_in;
			assign np = neg_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign np = neg_s[i-1];
		end
		assign xsh = xp >>> i;
		assign ysh = yp >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (zp >= 0) begin
					x_s[i] <= xp - ysh;
					y_s[i] <= yp + xsh;
					z_s[i] <= zp - atan_q30(i);
				end else begin
					x_s[i] <= xp + ysh;
					y_s[i] <= yp - xsh;
					z_s[i] <= zp + atan_q30(i);
				end
				neg_s[i] <= np;
			end
		end
	end

	assign x_out   = x_s[STEPS-1];
	assign y_out   = y_s[STEPS-1];
	assign neg_out = neg_s[STEPS-1];

endmodule

/* src/ump_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ump_div
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module ump_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [ump_pkg::NH_W-1:0]        num_in,
	input  logic [ump_pkg::DVS_W-1:0]       dvs_in,
	output logic [ump_pkg::NH_W-1:0]        q_out
);
	import ump_pkg::*;

	logic [DVS_W-1:0] rem_s [NH_W];
	logic [NH_W-1:0]  num_s [NH_W];
	logic [NH_W-1:0]  q_s   [NH_W];
	logic [DVS_W-1:0] dvs_s [NH_W];

	for (genvar k = 0; k < NH_W; k++) begin : g_bit
		logic [DVS_W-1:0] rp, dp;
		logic [NH_W-1:0]  np, qp;
		logic [DVS_W:0]   trial, diff;
		if (k == 0) begin : g_first
			assign rp = '0;
			assign np = num_in;
			assign qp = '0;
			assign dp = dvs_in;
		end else begin : g_next
			assign rp = rem_s[k-1];
			assign np = num_s[k-1];
			assign qp = q_s[k-1];
			assign dp = dvs_s[k-1];
		end
		assign trial = {rp, np[NH_W-1]};
		assign diff  = trial - {1'b0, dp};
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, dp}) begin
					rem_s[k] <= diff[DVS_W-1:0];
					q_s[k]   <= {qp[NH_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial[DVS_W-1:0];
					q_s[k]   <= {qp[NH_W-2:0], 1'b0};
				end
				num_s[k] <= {np[NH_W-2:0], 1'b0};
				dvs_s[k] <= dp;
			end
		end
	end

	assign q_out = q_s[NH_W-1];

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the unicycle motion step unit against a bit-exact pose predictor:
// directed extremes and special cases, then random requests under several
// time steps, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;
	import ump_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0]  nx;
		logic signed [POS_W-1:0]  ny;
		logic signed [HEAD_W-1:0] nh;
	} pose_t;

	localparam longint P_PI   = 64'sd3373259426;
	localparam longint P_HPI  = 64'sd1686629713;
	localparam longint P_2PI  = 64'sd6746518852;
	localparam longint P_GAIN = 64'sd652032875;
	localparam int     LATENCY = 32 + 16;
	localparam longint CYCLE_LIMIT = 400000;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [103:0]  s_axis_tdata;   // pos_x, pos_y, heading, speed, turn_rate
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [71:0]   m_axis_tdata;   // next_x, next_y, next_heading
	logic          cfg_wr_en;
	logic [15:0]   cfg_wr_data;

	logic [15:0] step_len;
	pose_t       pose_q[$];
	int          errors;
	int          matched;
	longint      cycles;
	bit          sink_busy;    // when clear, sink never stalls
	bit          src_busy;

	unicycle_motion_step_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 << (s - 1))) >> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint rnd_div(longint n, longint d);
		longint an, ad, q;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		q = (an + ad / 2) / ad;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic longint sat(longint v, int w);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic void sin_cos(longint a, output longint sn, output longint cs);
		longint x, y, t;
		bit neg;
		x = P_GAIN; y = 0; neg = 0;
		for (int i = 0; i < 3; i++) begin
			if (a > P_PI) a -= P_2PI;
			else if (a <= -P_PI) a += P_2PI;
		end
		if (a > P_HPI) begin
			a -= P_PI; neg = 1;
		end else if (a < -P_HPI) begin
			a += P_PI; neg = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (a >= 0) begin
				t = x - asr64(y, i); y = y + asr64(x, i); a -= longint'(atan_q30(i));
			end else begin
				t = x + asr64(y, i); y = y - asr64(x, i); a += longint'(atan_q30(i));
			end
			x = t;
		end
		sn = neg ? -y : y;
		cs = neg ? -x : x;
	endfunction

	function automatic pose_t next_pose(logic [103:0] d);
		longint px, py, th, v, w, dt, dth, s0, c0, s1, c1, dx, dy, travel;
		pose_t r;
		px = longint'($signed(d[23:0]));
		py = longint'($signed(d[47:24]));
		th = longint'($signed(d[67:48]));
		v  = longint'(d[84:68]);
		w  = longint'($signed(d[101:85]));
		dt = longint'(step_len);
		dth = rnd_shift(w * dt, FRAC_BITS);
		sin_cos(th * (64'sd1 << ANG_SHIFT), s0, c0);
		if (w == 0) begin
			travel = rnd_shift(v * dt, FRAC_BITS);
			dx = rnd_shift(travel * c0, TRIG_Q);
			dy = rnd_shift(travel * s0, TRIG_Q);
		end else begin
			sin_cos((th + dth) * (64'sd1 << ANG_SHIFT), s1, c1);
			dx = rnd_div(v * (s1 - s0), w * (64'sd1 << TRIG_Q));
			dy = rnd_div(v * (c0 - c1), w * (64'sd1 << TRIG_Q));
		end
		r.nx = POS_W'(sat(px + dx, POS_W));
		r.ny = POS_W'(sat(py + dy, POS_W));
		r.nh = HEAD_W'(sat(th + dth, HEAD_W));
		return r;
	endfunction

	// drive one request, with optional idle cycles in front
	task automatic send_pose(logic [23:0] px, logic [23:0] py, logic [19:0] th,
			logic [16:0] v, logic [16:0] w);
		while (src_busy && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, w, v, th, py, px};
		do @(posedge clk); while (!s_axis_tready);
		pose_q.push_back(next_pose({2'b00, w, v, th, py, px}));
	endtask

	task automatic drain_and_set(logic [15:0] val);
		s_axis_tvalid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		step_len  = val;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic rand_pose(bit wide);
		logic [16:0] v, w;
		if (wide) begin
			v = 17'($urandom);
			w = 17'($urandom);
		end else begin
			v = 17'($urandom_range(98304));
			w = 17'($urandom_range(102944)) - 17'd51472;
		end
		if ($urandom_range(9) == 0) w = '0;
		send_pose(24'($urandom), 24'($urandom), 20'($urandom), v, w);
	endtask

	task automatic test_directed();
		send_pose(24'h000000, 24'h000000, 20'h00000, 17'd65536, 17'd0);
		send_pose(24'h7FFFFF, 24'h7FFFFF, 20'h7FFFF, 17'd98304, 17'd0);
		send_pose(24'h800000, 24'h800000, 20'h80000, 17'd98304, 17'd0);
		send_pose(24'h7FFFFF, 24'h800000, 20'h7FFFF, 17'h1FFFF, 17'h0FFFF);
		send_pose(24'h800000, 24'h7FFFFF, 20'h80000, 17'h1FFFF, 17'h10000);
		send_pose(24'h000000, 24'h000000, 20'h7FFFF, 17'd98304, 17'd51472);
		send_pose(24'h000000, 24'h000000, 20'h80000, 17'd98304, -17'sd51472);
		send_pose(24'h123456, 24'hABCDEF, 20'd102944, 17'd40000, 17'd1);
		send_pose(24'h123456, 24'hABCDEF, -20'sd102944, 17'd40000, -17'sd1);
		send_pose(24'h000000, 24'h000000, 20'd205887, 17'd65536, 17'd25736);
		send_pose(24'h000000, 24'h000000, 20'd0, 17'd0, 17'd30000);
		send_pose(24'h555555, 24'hAAAAAA, 20'h55555, 17'h15555, 17'h0AAAA);
		send_pose(24'hAAAAAA, 24'h555555, 20'hAAAAA, 17'h0AAAA, 17'h15555);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			src_busy  = (i % 200) >= 60;
			sink_busy = (i % 300) >= 80;
			rand_pose($urandom_range(7) == 0);
		end
		src_busy = 1; sink_busy = 1;
	endtask

	// result checker and sink
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				if (pose_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_axis_tdata);
					errors <= errors + 1;
				end else begin
					pose_t e;
					e = pose_q.pop_front();
					if (m_axis_tdata[23:0] !== e.nx || m_axis_tdata[47:24] !== e.ny ||
							m_axis_tdata[67:48] !== e.nh) begin
						$display("%0t: pose mismatch exp x=%h y=%h h=%h got x=%h y=%h h=%h",
							$time, e.nx, e.ny, e.nh, m_axis_tdata[23:0],
							m_axis_tdata[47:24], m_axis_tdata[67:48]);
						errors <= errors + 1;
					end else begin
						matched <= matched + 1;
					end
				end
			end
			m_axis_tready <= !(sink_busy && $urandom_range(99) < 22);
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("[unicycle_motion_step_unit] ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0; matched = 0; cycles = 0;
		sink_busy = 1; src_busy = 1;
		step_len = TIME_STEP_RST;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en = 1'b0; cfg_wr_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200);
		drain_and_set(16'd0);
		test_directed();
		test_random(100);
		drain_and_set(16'hFFFF);
		test_directed();
		test_random(300);
		drain_and_set(16'd1);
		test_random(150);
		drain_and_set(16'($urandom_range(65535, 1)));
		test_random(450);
		s_axis_tvalid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d poses over time steps 6554, 0, 65535, 1 and one random value,",
			matched);
		$display("straight and arc paths, field extremes and out-of-range fields.");
		if (errors == 0)
			$display("[unicycle_motion_step_unit] OK");
		else
			$display("[unicycle_motion_step_unit] ERROR");
		$finish;
	end
endmodule
